>>> src/hckx_pkg.sv
package hckx_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [4:0] offset;
    logic       new_block;
  } work_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ROUND = 2'd1,
    BK_FINAL = 2'd2,
    BK_EMIT  = 2'd3
  } bk_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

endpackage

>>> src/hckx_data_if.sv
interface hckx_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source(output valid, data_byte, last, input ready);
  modport sink(input valid, data_byte, last, output ready);
endinterface

>>> src/hckx_out_if.sv
interface hckx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source(output valid, out_byte, out_last, input ready);
  modport sink(input valid, out_byte, out_last, output ready);
endinterface

>>> src/hckx_cfg_if.sv
interface hckx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/hckx_front.sv
// Tracks byte offset and tags each request that opens a keystream block.
module hckx_front (
  input  logic               clk,
  input  logic               rst,
  hckx_data_if.sink          din,
  output hckx_pkg::work_t    q_wdata,
  output logic               q_push,
  input  logic               q_full
);
  import hckx_pkg::*;

  logic [4:0] offset;

  assign din.ready = !q_full;
  assign q_push    = din.valid && !q_full;

  always_comb begin
    q_wdata.data      = din.data_byte;
    q_wdata.last      = din.last;
    q_wdata.offset    = offset;
    q_wdata.new_block = (offset == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (q_push) begin
      offset <= din.last ? 5'd0 : offset + 5'd1;
    end
  end

endmodule

>>> src/hckx_queue.sv
module hckx_queue (
  input  logic            clk,
  input  logic            rst,
  input  hckx_pkg::work_t wdata,
  input  logic            push,
  output logic            full,
  output hckx_pkg::work_t rdata,
  output logic            empty,
  input  logic            pop
);
  import hckx_pkg::*;

  work_t      mem [QDepth];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'(QDepth));
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) count <= 2'(QDepth))
    else $error("queue count out of range");

endmodule

>>> src/hckx_back.sv
// Runs SHA-256 one round a cycle at block start, then XORs and emits.
module hckx_back (
  input  logic            clk,
  input  logic            rst,
  input  hckx_pkg::work_t q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic [255:0]    key,
  input  logic [31:0]     nonce,
  hckx_out_if.source      dout
);
  import hckx_pkg::*;

  bk_state_t   state, state_next;
  logic [31:0] counter;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic [255:0] ks;
  logic [7:0]  obyte;
  logic        olast;
  logic        ovalid;

  logic [31:0] wt, w_new, s0, s1, ch, maj, t1, t2, a2, a15;
  logic        start, emit_ok;

  assign emit_ok = !ovalid || dout.ready;
  assign start   = (state == BK_IDLE) && !q_empty;

  always_comb begin
    a2  = w[4'(rnd - 6'd2)];
    a15 = w[4'(rnd - 6'd15)];
    w_new = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + w[4'(rnd - 6'd7)]
          + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w[rnd[3:0]];
    wt  = (rnd >= 6'd16) ? w_new : w[rnd[3:0]];
    s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + s1 + ch + round_k(rnd) + wt;
    s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = s0 + maj;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = q_rdata.new_block ? BK_ROUND : BK_EMIT;
        end
      end
      BK_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = BK_FINAL;
        end
      end
      BK_FINAL: state_next = BK_EMIT;
      BK_EMIT: begin
        if (emit_ok) begin
          q_pop      = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd     <= '0;
      counter <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (state == BK_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (ovalid && dout.ready) begin
        ovalid <= 1'b0;
      end
      if (q_pop) begin
        ovalid <= 1'b1;
        if (q_rdata.last) begin
          counter <= '0;
        end else if (q_rdata.offset == 5'd31) begin
          counter <= counter + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && q_rdata.new_block) begin
      for (int i = 0; i < 8; i++) begin
        w[i] <= key[255 - 32*i -: 32];
        v[i] <= init_h(3'(i));
      end
      w[8]  <= nonce;
      w[9]  <= counter;
      w[10] <= 32'h80000000;
      w[11] <= '0;
      w[12] <= '0;
      w[13] <= '0;
      w[14] <= '0;
      w[15] <= 32'd320;
    end else if (state == BK_ROUND) begin
      w[rnd[3:0]] <= wt;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (state == BK_FINAL) begin
      for (int i = 0; i < 8; i++) begin
        ks[255 - 32*i -: 32] <= v[i] + init_h(3'(i));
      end
    end
    if (q_pop) begin
      obyte <= q_rdata.data ^ ks[8'(255 - 8*q_rdata.offset) -: 8];
      olast <= q_rdata.last;
    end
  end

  assign dout.valid    = ovalid;
  assign dout.out_byte = obyte;
  assign dout.out_last = olast;

  assert property (@(posedge clk) disable iff (rst)
    (state == BK_ROUND) |-> !q_empty)
    else $error("hash running with no request");
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_FINAL) |-> $past(rnd) == 6'd63)
    else $error("finalize before last round");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_EMIT) && emit_ok)
    else $error("pop outside emit");

endmodule

>>> src/hash_counter_keystream_xor.sv
// channel | dir | fields
// din     | in  | data_byte[7:0], last
// dout    | out | out_byte[7:0], out_last
// cfg     | in  | index[2:0], data[63:0]
// For a byte opening a 32-byte block the hash runs 64 SHA-256 rounds, one a cycle
// in a single round unit, then finalizes and emits; other bytes go straight to
// emit. rst is synchronous and clears offset, counter, queue, output valid, key
// and nonce. A two-entry queue parts the offset tracker from the hash; the output
// register holds while dout.ready is low.
module hash_counter_keystream_xor (
  input  logic       clk,
  input  logic       rst,
  hckx_data_if.sink  din,
  hckx_out_if.source dout,
  hckx_cfg_if.sink   cfg
);
  import hckx_pkg::*;

  logic [63:0]  key_word [4];
  logic [31:0]  nonce;
  work_t        q_wdata, q_rdata;
  logic         q_push, q_pop, q_full, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_word[i] <= '0;
      end
      nonce <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY0:  key_word[0] <= cfg.data;
        REG_KEY1:  key_word[1] <= cfg.data;
        REG_KEY2:  key_word[2] <= cfg.data;
        REG_KEY3:  key_word[3] <= cfg.data;
        REG_NONCE: nonce       <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  hckx_front u_front (
    .clk, .rst, .din, .q_wdata, .q_push, .q_full
  );

  hckx_queue u_queue (
    .clk, .rst, .wdata(q_wdata), .push(q_push), .full(q_full),
    .rdata(q_rdata), .empty(q_empty), .pop(q_pop)
  );

  hckx_back u_back (
    .clk, .rst, .q_rdata, .q_empty, .q_pop,
    .key({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .nonce, .dout
  );

endmodule

>>> dv/hash_counter_keystream_xor_tb.sv
module hash_counter_keystream_xor_tb;
  import hckx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_out_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic clk = 1'b0;
  logic rst = 1'b1;

  hckx_data_if din();
  hckx_out_if  dout();
  hckx_cfg_if  cfg();

  hash_counter_keystream_xor DUT (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [63:0]  key_w [4];
  logic [31:0]  nonce;
  logic [31:0]  blk_ctr;
  logic [4:0]   byte_off;
  logic [255:0] ks_block;

  cipher_out_t expected_q[$];
  int  errors = 0;
  bit  gaps_on = 1'b1;
  bit  hold_sink = 1'b0;
  int  hold_cycles = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] block_digest(logic [31:0] ctr);
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, a2, a15;
    logic [255:0] d;
    for (int i = 0; i < 4; i++) begin
      w[2*i] = key_w[i][63:32];
      w[2*i+1] = key_w[i][31:0];
    end
    w[8] = nonce;
    w[9] = ctr;
    w[10] = 32'h80000000;
    for (int i = 11; i < 15; i++) w[i] = '0;
    w[15] = 32'd320;
    for (int i = 0; i < 8; i++) v[i] = SHA_IV[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        a2 = w[(t-2) & 15];
        a15 = w[(t-15) & 15];
        w[t & 15] = (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10)) + w[(t-7) & 15]
                  + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + w[t & 15];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) d[255 - 32*i -: 32] = v[i] + SHA_IV[i];
    return d;
  endfunction

  function automatic void predict_cipher(logic [7:0] b, logic l);
    cipher_out_t e;
    if (byte_off == 0) ks_block = block_digest(blk_ctr);
    e.out_byte = b ^ ks_block[255 - 8*byte_off -: 8];
    e.out_last = l;
    expected_q.push_back(e);
    byte_off = byte_off + 1;
    if (byte_off == 0) blk_ctr = blk_ctr + 1;
    if (l) begin
      blk_ctr = '0;
      byte_off = '0;
    end
  endfunction

  initial begin
    din.valid = 1'b0;
    din.data_byte = '0;
    din.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    dout.ready = 1'b0;
  end

  task automatic send_byte(logic [7:0] b, logic l);
    int g;
    if (gaps_on && $urandom_range(3) == 0) begin
      g = $urandom_range(1, 3);
      din.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.data_byte <= b;
    din.last <= l;
    predict_cipher(b, l);
    do @(posedge clk); while (!din.ready);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (r == REG_NONCE) nonce = val[31:0];
    else key_w[2'(r)] = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_byte($urandom_range(255), i == n - 1);
    din.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h55, 1'b1);
    for (int i = 0; i < 19; i++) send_byte(8'hff, i == 18);
    din.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_key_extremes();
    wait_drained();
    for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), '1);
    write_reg(REG_NONCE, 64'hffff_ffff);
    send_message(40);
    wait_drained();
    for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), {$urandom, $urandom});
    write_reg(REG_NONCE, {$urandom, $urandom});
    send_message(70);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 200) @(posedge clk);
        hold_sink = 1'b0;
      end
      send_message(10);
    join
  endtask

  task automatic test_random();
    int n;
    for (int k = 0; k < 6; k++) begin
      wait_drained();
      write_reg(cfg_reg_t'($urandom_range(4)), {$urandom, $urandom});
      repeat (5) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
        send_message(n);
      end
    end
    gaps_on = 1'b0;
    send_message(80);
  endtask

  always @(posedge clk) begin
    if (hold_sink) hold_cycles <= hold_cycles + 1;
    if (rst || hold_sink) dout.ready <= 1'b0;
    else if (gaps_on) dout.ready <= ($urandom_range(3) != 0);
    else dout.ready <= 1'b1;
  end

  always @(posedge clk) begin
    cipher_out_t e;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, dout.out_byte,
                 dout.out_last);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (dout.out_byte !== e.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
                   dout.out_byte);
          errors++;
        end
        if (dout.out_last !== e.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time, e.out_last,
                   dout.out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    nonce = '0;
    blk_ctr = '0;
    byte_off = '0;
    ks_block = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_key_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) $display("hash_counter_keystream_xor_tb: clean");
    else $display("hash_counter_keystream_xor_tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("hash_counter_keystream_xor_tb: errors");
    $finish;
  end
endmodule

>>> files.f
src/hckx_pkg.sv
src/hckx_data_if.sv
src/hckx_out_if.sv
src/hckx_cfg_if.sv
src/hckx_front.sv
src/hckx_queue.sv
src/hckx_back.sv
src/hash_counter_keystream_xor.sv
dv/hash_counter_keystream_xor_tb.sv
